>>> hdl/euler_to_rotation_matrix_assert.svh
// Assertion macros for the Euler-to-rotation-matrix block
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH

// implication checked on every edge outside reset
`define E2R_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2r check failed");

// next-cycle implication
`define E2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2r check failed");

`endif

>>> hdl/e2r_pkg.sv
// Types and constants shared by the Euler-to-rotation-matrix block
package e2r_pkg;

    localparam int TABLE_LEN = 24;
    localparam int W = 34;   // Q2.30 datapath plus headroom

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } out_beat_t;

    function automatic logic signed [W-1:0] atan_turn(input int i);
        case (i)
            0:  atan_turn = 34'sd536870912;
            1:  atan_turn = 34'sd316933406;
            2:  atan_turn = 34'sd167458907;
            3:  atan_turn = 34'sd85004756;
            4:  atan_turn = 34'sd42667331;
            5:  atan_turn = 34'sd21354465;
            6:  atan_turn = 34'sd10679838;
            7:  atan_turn = 34'sd5340245;
            8:  atan_turn = 34'sd2670163;
            9:  atan_turn = 34'sd1335087;
            10: atan_turn = 34'sd667544;
            11: atan_turn = 34'sd333772;
            12: atan_turn = 34'sd166886;
            13: atan_turn = 34'sd83443;
            14: atan_turn = 34'sd41722;
            15: atan_turn = 34'sd20861;
            16: atan_turn = 34'sd10430;
            17: atan_turn = 34'sd5215;
            18: atan_turn = 34'sd2608;
            19: atan_turn = 34'sd1304;
            20: atan_turn = 34'sd652;
            21: atan_turn = 34'sd326;
            22: atan_turn = 34'sd163;
            23: atan_turn = 34'sd81;
            default: atan_turn = '0;
        endcase
    endfunction

endpackage

>>> hdl/e2r_cordic.sv
// Pipelined sine/cosine lane: quadrant reduction, CORDIC stages, Q2.16 rounding
module e2r_cordic #(
    parameter int STAGES     = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic signed [15:0] angle,
    output logic signed [17:0] cos_q16,
    output logic signed [17:0] sin_q16
);
    localparam int W  = e2r_pkg::W;
    localparam int NS = (STAGES < e2r_pkg::TABLE_LEN) ? STAGES : e2r_pkg::TABLE_LEN;
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic [31:0] phase, resid;
    logic [1:0]  quad;

    logic signed [W-1:0] x_reg [0:NS];
    logic signed [W-1:0] y_reg [0:NS];
    logic signed [W-1:0] z_reg [0:NS];
    logic [1:0]          q_reg [0:NS];
    logic signed [W-1:0] c_pre, s_pre, c_rnd, s_rnd;

    always_comb
    begin
        phase = {angle, 16'd0} & KEEP;
        quad  = 2'(((phase + 32'h4000_0000) >> 30));
        resid = phase - {quad, 30'd0};
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= 34'sd652032874;
        y_reg[0] <= '0;
        z_reg[0] <= {{2{resid[31]}}, resid};
        q_reg[0] <= quad;
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge clk)
        begin
            q_reg[i+1] <= q_reg[i];
            if (!z_reg[i][W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - e2r_pkg::atan_turn(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + e2r_pkg::atan_turn(i);
            end
        end
    end

    always_comb
    begin
        case (q_reg[NS])
            2'd0:    begin c_pre =  x_reg[NS]; s_pre =  y_reg[NS]; end
            2'd1:    begin c_pre = -y_reg[NS]; s_pre =  x_reg[NS]; end
            2'd2:    begin c_pre = -x_reg[NS]; s_pre = -y_reg[NS]; end
            default: begin c_pre =  y_reg[NS]; s_pre = -x_reg[NS]; end
        endcase
        c_rnd = (c_pre + 34'sd8192) >>> 14;
        s_rnd = (s_pre + 34'sd8192) >>> 14;
    end

    function automatic logic signed [17:0] sat(input logic signed [W-1:0] v);
        if (v > 34'sd65536)       sat = 18'sd65536;
        else if (v < -34'sd65536) sat = -18'sd65536;
        else                      sat = 18'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        cos_q16 <= sat(c_rnd);
        sin_q16 <= sat(s_rnd);
    end
endmodule

>>> hdl/e2r_merge.sv
// Merging stage: products and sums of the lane outputs into nine Q1.14 entries
module e2r_merge (
    input  logic               clk,
    input  logic signed [17:0] cy, sy, cp, sp, cr, sr,
    output e2r_pkg::out_beat_t res
);
    // stage 1: first products
    logic signed [35:0] cycp_reg, sycp_reg, cpsr_reg, cpcr_reg;
    logic signed [35:0] sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    logic signed [35:0] cysp_reg, sysp_reg;
    logic signed [17:0] sp1_reg, cr1_reg, sr1_reg;
    // stage 2: triple products and passed doubles
    logic signed [35:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [35:0] d00_reg, d10_reg, d21_reg, d22_reg;
    logic signed [35:0] d01_reg, d02_reg, d11_reg, d12_reg;
    logic signed [17:0] sp2_reg;
    logic signed [19:0] a_cysp, a_sysp;

    always_ff @(posedge clk)
    begin
        cycp_reg <= cy * cp;  sycp_reg <= sy * cp;
        cpsr_reg <= cp * sr;  cpcr_reg <= cp * cr;
        sycr_reg <= sy * cr;  sysr_reg <= sy * sr;
        cycr_reg <= cy * cr;  cysr_reg <= cy * sr;
        cysp_reg <= cy * sp;  sysp_reg <= sy * sp;
        sp1_reg <= sp; cr1_reg <= cr; sr1_reg <= sr;
    end

    // products stay within 2^32, so the rounded Q.16 value fits 20 bits
    assign a_cysp = 20'((cysp_reg + 36'sd32768) >>> 16);
    assign a_sysp = 20'((sysp_reg + 36'sd32768) >>> 16);

    always_ff @(posedge clk)
    begin
        t01_reg <= 36'(a_cysp * sr1_reg);
        t02_reg <= 36'(a_cysp * cr1_reg);
        t11_reg <= 36'(a_sysp * sr1_reg);
        t12_reg <= 36'(a_sysp * cr1_reg);
        d00_reg <= cycp_reg; d10_reg <= sycp_reg;
        d21_reg <= cpsr_reg; d22_reg <= cpcr_reg;
        d01_reg <= sycr_reg; d02_reg <= sysr_reg;
        d11_reg <= cycr_reg; d12_reg <= cysr_reg;
        sp2_reg <= sp1_reg;
    end

    function automatic logic signed [15:0] ent(input logic signed [36:0] v);
        logic signed [36:0] r;
        r = (v + 37'sd131072) >>> 18;
        if (r > 37'sd16384)       ent = 16'sd16384;
        else if (r < -37'sd16384) ent = -16'sd16384;
        else                      ent = 16'(r);
    endfunction

    logic signed [18:0] m20_r;
    assign m20_r = (19'sd2 - 19'(sp2_reg)) >>> 2;

    always_ff @(posedge clk)
    begin
        res.m00 <= ent(37'(d00_reg));
        res.m01 <= ent(37'(t01_reg) - 37'(d01_reg));
        res.m02 <= ent(37'(t02_reg) + 37'(d02_reg));
        res.m10 <= ent(37'(d10_reg));
        res.m11 <= ent(37'(t11_reg) + 37'(d11_reg));
        res.m12 <= ent(37'(t12_reg) - 37'(d12_reg));
        res.m20 <= 16'(m20_r);
        res.m21 <= ent(37'(d21_reg));
        res.m22 <= ent(37'(d22_reg));
    end
endmodule

>>> hdl/euler_to_rotation_matrix.sv
// Euler Z-Y-X angles to 3x3 rotation matrix, top level
// Fully pipelined: one angle set may be started every cycle (busy stays low).
// The matrix appears on res with done high once the angles have passed the three
// CORDIC lanes (stage count clipped to 24) and the three-stage product and rounding
// merge. done lasts one cycle and the receiver cannot hold it off.
module euler_to_rotation_matrix #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  e2r_pkg::in_beat_t  req,
    output logic               done,
    output e2r_pkg::out_beat_t res
);
    localparam int NS  = (CORDIC_STAGES < e2r_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : e2r_pkg::TABLE_LEN;
    localparam int LAT = NS + 5;

    logic signed [17:0] cy, sy, cp, sp, cr, sr;
    logic [LAT-1:0] vld_reg, vld_next;

    e2r_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk(clk), .angle(req.yaw_angle), .cos_q16(cy), .sin_q16(sy));
    e2r_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk(clk), .angle(req.pitch_angle), .cos_q16(cp), .sin_q16(sp));
    e2r_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk(clk), .angle(req.roll_angle), .cos_q16(cr), .sin_q16(sr));

    e2r_merge u_merge (
        .clk(clk), .cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr), .res(res));

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};
    assign done     = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

`include "euler_to_rotation_matrix_assert.svh"

    `E2R_ASSERT_NEXT(a_start_tracked, start, vld_reg[0])
    `E2R_ASSERT_IMP(a_never_busy, start, !busy)
    `E2R_ASSERT_IMP(a_entry_range, done, (res.m00 <= 16'sd16384) && (res.m00 >= -16'sd16384))

endmodule

>>> tb/sv/euler_to_rotation_matrix_checker.sv
// Checker for the Euler-to-rotation-matrix block: predicts each matrix and compares
module euler_to_rotation_matrix_checker #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  e2r_pkg::in_beat_t  req,
    input  logic               done,
    input  e2r_pkg::out_beat_t res,
    output int                 fail_count,
    output int                 pending,
    output int                 matrices_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint GAIN_INV  = 652032874;
    localparam longint TRIG_MAX  = 65536;
    localparam longint ENTRY_MAX = 16384;

    e2r_pkg::out_beat_t matrix_q[$];

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // sine and cosine in Q2.16 of one binary angle
    function automatic void angle_trig(input logic [15:0] ang, output longint c,
                                       output longint s);
        logic [31:0] keep;
        logic [31:0] phase;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint x, y, z, xs, ys, tc, ts;
        int nst;
        keep  = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
        phase = {ang, 16'h0} & keep;
        quad  = 2'((phase + 32'h4000_0000) >> 30);
        resid = phase - ({30'd0, quad} << 30);
        z = longint'(signed'(resid));
        x = GAIN_INV;
        y = 0;
        nst = (CORDIC_STAGES < e2r_pkg::TABLE_LEN) ? CORDIC_STAGES : e2r_pkg::TABLE_LEN;
        for (int i = 0; i < nst; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(e2r_pkg::atan_turn(i));
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(e2r_pkg::atan_turn(i));
            end
        end
        case (quad)
            2'd0:    begin tc = x;  ts = y;  end
            2'd1:    begin tc = -y; ts = x;  end
            2'd2:    begin tc = -x; ts = -y; end
            default: begin tc = y;  ts = -x; end
        endcase
        c = sat((tc + 8192) >>> 14, TRIG_MAX);
        s = sat((ts + 8192) >>> 14, TRIG_MAX);
    endfunction

    function automatic longint triple(input longint a, input longint b, input longint c);
        return ((a * b + 32768) >>> 16) * c;
    endfunction

    function automatic logic [15:0] to_entry(input longint v);
        return 16'(sat((v + 131072) >>> 18, ENTRY_MAX));
    endfunction

    function automatic e2r_pkg::out_beat_t rotation_of(input e2r_pkg::in_beat_t a);
        longint cy, sy, cp, sp, cr, sr;
        e2r_pkg::out_beat_t m;
        angle_trig(a.yaw_angle, cy, sy);
        angle_trig(a.pitch_angle, cp, sp);
        angle_trig(a.roll_angle, cr, sr);
        m.m00 = to_entry(cy * cp);
        m.m01 = to_entry(triple(cy, sp, sr) - sy * cr);
        m.m02 = to_entry(triple(cy, sp, cr) + sy * sr);
        m.m10 = to_entry(sy * cp);
        m.m11 = to_entry(triple(sy, sp, sr) + cy * cr);
        m.m12 = to_entry(triple(sy, sp, cr) - cy * sr);
        m.m20 = 16'(sat((-sp + 2) >>> 2, ENTRY_MAX));
        m.m21 = to_entry(cp * sr);
        m.m22 = to_entry(cp * cr);
        return m;
    endfunction

    initial
    begin
        fail_count    = 0;
        matrices_seen = 0;
        pending       = 0;
    end

    always @(posedge clk)
    begin
        e2r_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (done)
            begin
                matrices_seen++;
                if (matrix_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected matrix %h", $realtime, res);
                end
                else
                begin
                    want = matrix_q.pop_front();
                    if (res !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: matrix mismatch exp %h got %h", $realtime,
                                     want, res);
                    end
                end
            end
            if (start && !busy)
                matrix_q.push_back(rotation_of(req));
        end
        pending <= matrix_q.size();
    end
endmodule

>>> tb/sv/tb_euler_to_rotation_matrix.sv
// Testbench top for the Euler-to-rotation-matrix block: stimulus and verdict
module tb_euler_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 950;
    localparam int MAX_TICKS = 200000;
    localparam int LATENCY   = 16 + 5;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    e2r_pkg::in_beat_t  req;
    logic               done;
    e2r_pkg::out_beat_t res;
    int                 fail_count;
    int                 pending;
    int                 matrices_seen;
    int                 ticks;
    int                 angle_sets;

    euler_to_rotation_matrix dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .res(res)
    );

    euler_to_rotation_matrix_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .fail_count(fail_count), .pending(pending),
        .matrices_seen(matrices_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        ticks = 0;
        forever
        begin
            @(posedge clk);
            ticks++;
            if (ticks > MAX_TICKS)
            begin
                $display("timeout after %0d cycles", ticks);
                $display("FAIL euler_to_rotation_matrix");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    // one beat offered; held until accepted
    task automatic send_angles(input e2r_pkg::in_beat_t a, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        angle_sets++;
    endtask

    initial
    begin
        logic [15:0] corners[8];
        e2r_pkg::in_beat_t a;
        corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000,
                    16'h2000, 16'h0001, 16'hFFFF};
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        angle_sets = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corner angles on each axis, then all bits set and alternating bit patterns
        for (int i = 0; i < 8; i++)
        begin
            a.yaw_angle   = corners[i];
            a.pitch_angle = corners[(i + 3) % 8];
            a.roll_angle  = corners[(i + 5) % 8];
            send_angles(a, 1'b0);
        end
        for (int i = 0; i < 8; i++)
        begin
            a = '0;
            a.pitch_angle = corners[i];
            a.roll_angle  = corners[7 - i];
            send_angles(a, 1'b1);
        end
        send_angles({16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
        send_angles({16'h5555, 16'hAAAA, 16'h5555}, 1'b0);

        // drain fully before resuming
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            a.yaw_angle   = pick_angle();
            a.pitch_angle = pick_angle();
            a.roll_angle  = pick_angle();
            // back-to-back burst in the middle of the run
            send_angles(a, !(n >= 300 && n < 450));
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        $display("%0d angle sets sent, %0d matrices checked, corner and random angles",
                 angle_sets, matrices_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS euler_to_rotation_matrix");
        else
            $display("FAIL euler_to_rotation_matrix");
        $finish;
    end
endmodule
